// ===== hdl/rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared widths, constants and types of the Gaussian RBF kernel evaluator.
// ----------------------------------------------------------------------------
package rbf_pkg;

    localparam int FEATURE_BITS = 16;
    localparam int PROD_W       = 2 * FEATURE_BITS;
    localparam int ACC_W        = 48;
    localparam int NORM_W       = 41;
    localparam int DIST_W       = 43;
    localparam int GAMMA_W      = 24;
    localparam int GAMMA_FRAC   = 16;
    localparam int KERNEL_W     = 17;

    localparam logic [GAMMA_W-1:0]  GAMMA_RESET = 24'd65536;
    localparam logic [ACC_W-1:0]    ACC_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W:0] CROSS_HI  = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W:0] CROSS_LO  = 49'sh1_8000_0000_0000;
    localparam logic [DIST_W-1:0]   DIST_MAX    = 43'h7FF_FFFF_FFFF;
    localparam logic [KERNEL_W-1:0] KERNEL_ONE  = 17'h1_0000;

    localparam int DWIDE_W    = ACC_W + 3;
    localparam int DIST_SPLIT = 20;
    localparam int PROD_HI_W  = GAMMA_W + DIST_W - DIST_SPLIT;
    localparam int PROD_LO_W  = GAMMA_W + DIST_SPLIT;
    localparam int A24_W      = PROD_HI_W + DIST_SPLIT - GAMMA_FRAC;

    localparam int Q30_W        = 30;
    localparam int A30_SHIFT    = 6;
    localparam int N_W          = 4;
    localparam int RCNT_W       = 2;
    localparam int RANGE_W      = Q30_W + N_W;
    localparam int TERM_W       = Q30_W + 1;
    localparam int TPROD_W      = TERM_W + Q30_W;
    localparam int SUM_W        = 32;
    localparam int K_W          = 4;
    localparam int RECIP_W      = 31;
    localparam int RSH_W        = 3;
    localparam int TAYLOR_TERMS = 10;
    localparam int RND_BASE     = 13;

    localparam logic [Q30_W-1:0]  LN2_Q30       = 30'd744261118;
    localparam logic [TERM_W-1:0] ONE_Q30       = 31'h4000_0000;
    localparam logic [A24_W-1:0]  EXP_BOUND_A24 = 51'd186065279;

    // ceil(2^(30+s)/k) with s = ceil(log2 k)
    localparam logic [RECIP_W-1:0] RECIP_POW2 = 31'd1073741824;
    localparam logic [RECIP_W-1:0] RECIP_3    = 31'd1431655766;
    localparam logic [RECIP_W-1:0] RECIP_5    = 31'd1717986919;
    localparam logic [RECIP_W-1:0] RECIP_7    = 31'd1227133514;
    localparam logic [RECIP_W-1:0] RECIP_9    = 31'd1908874354;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    typedef struct packed {
        logic [ACC_W-1:0]  self_dot;
        logic [ACC_W-1:0]  cross_dot;
        logic [NORM_W-1:0] norm;
    } job_t;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               not_empty;
    } q_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_BOUND,
        ST_RANGE,
        ST_MUL_TERM,
        ST_DIV,
        ST_ACCUM,
        ST_ROUND,
        ST_DONE
    } back_state_t;

endpackage

// ===== hdl/rbf_front.sv =====
// ----------------------------------------------------------------------------
// rbf_front
// Feature-pair intake: registered products, saturating dot-product
// accumulators, and hand-off of finished vector pairs to the job queue.
// ----------------------------------------------------------------------------
module rbf_front import rbf_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [FEATURE_BITS-1:0] test_feature,
    input  logic signed [FEATURE_BITS-1:0] ref_feature,
    input  logic        [NORM_W-1:0]       ref_norm_sq,
    input  logic                           last_feature,
    input  q_stat_t                        q_stat,
    output logic                           push,
    output job_t                           push_job
);

    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic signed [PROD_W-1:0] s1_sq_reg;
    logic signed [PROD_W-1:0] s1_xy_reg;
    logic [NORM_W-1:0]        s1_norm_reg;
    logic [ACC_W-1:0]         self_acc_reg;
    logic signed [ACC_W-1:0]  cross_acc_reg;

    logic                     accept;
    logic [ACC_W:0]           self_sum;
    logic signed [ACC_W:0]    cross_sum;
    logic [ACC_W-1:0]         self_sat;
    logic signed [ACC_W-1:0]  cross_sat;

    assign in_ready = (q_stat.count + Q_CNT_W'(s1_valid_reg & s1_last_reg))
                      < Q_CNT_W'(QUEUE_DEPTH);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        self_sum  = {1'b0, self_acc_reg} + (ACC_W+1)'($unsigned(s1_sq_reg));
        cross_sum = (ACC_W+1)'(cross_acc_reg) + (ACC_W+1)'(s1_xy_reg);
        self_sat  = (self_sum > {1'b0, ACC_MAX}) ? ACC_MAX : self_sum[ACC_W-1:0];
        if (cross_sum > CROSS_HI)
            cross_sat = CROSS_HI[ACC_W-1:0];
        else if (cross_sum < CROSS_LO)
            cross_sat = CROSS_LO[ACC_W-1:0];
        else
            cross_sat = cross_sum[ACC_W-1:0];
    end

    assign push               = s1_valid_reg && s1_last_reg;
    assign push_job.self_dot  = self_sat;
    assign push_job.cross_dot = cross_sat;
    assign push_job.norm      = s1_norm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            self_acc_reg  <= '0;
            cross_acc_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_last_reg  <= accept && last_feature;
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    self_acc_reg  <= '0;
                    cross_acc_reg <= '0;
                end
                else
                begin
                    self_acc_reg  <= self_sat;
                    cross_acc_reg <= cross_sat;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sq_reg   <= test_feature * test_feature;
            s1_xy_reg   <= test_feature * ref_feature;
            s1_norm_reg <= ref_norm_sq;
        end
    end

`ifndef SYNTH
    a_clear_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (self_acc_reg == '0) && (cross_acc_reg == '0))
        else $error("accumulators not cleared after vector pair hand-off");
`endif

endmodule

// ===== hdl/rbf_queue.sv =====
// ----------------------------------------------------------------------------
// rbf_queue
// Short job queue between the accumulating front and the kernel back end.
// ----------------------------------------------------------------------------
module rbf_queue import rbf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    pop_job,
    output q_stat_t q_stat
);

    job_t               slot_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        ptr_inc = (p == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign pop_job          = slot_reg[rd_ptr_reg];
    assign q_stat.count     = count_reg;
    assign q_stat.not_empty = (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < Q_CNT_W'(QUEUE_DEPTH)) || pop)
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("job queue underflow");
`endif

endmodule

// ===== hdl/rbf_back.sv =====
// ----------------------------------------------------------------------------
// rbf_back
// Kernel sequencer: distance, gamma scaling, range reduction, Taylor series
// of exp with a reciprocal-multiply divide, rounding, and the output register.
// ----------------------------------------------------------------------------
module rbf_back import rbf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [GAMMA_W-1:0]  cfg_wdata,
    input  q_stat_t             q_stat,
    input  job_t                pop_job,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KERNEL_W-1:0] kernel_value,
    output logic [DIST_W-1:0]   squared_distance
);

    back_state_t state_reg;
    back_state_t state_next;

    logic [GAMMA_W-1:0]   gamma_reg;
    logic                 out_valid_reg;
    logic [KERNEL_W-1:0]  kernel_out_reg;
    logic [DIST_W-1:0]    dist_out_reg;

    job_t                 job_reg;
    logic [DIST_W-1:0]    dist_reg;
    logic [PROD_HI_W-1:0] prod_hi_reg;
    logic [PROD_LO_W-1:0] prod_lo_reg;
    logic [RANGE_W-1:0]   rem_reg;
    logic [N_W-1:0]       n_reg;
    logic [RCNT_W-1:0]    range_cnt_reg;
    logic [TERM_W-1:0]    term_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [Q30_W-1:0]     qd_reg;
    logic [K_W-1:0]       k_reg;
    logic [KERNEL_W-1:0]  kernel_reg;

    logic                    load_out;
    logic signed [DWIDE_W-1:0] d_wide;
    logic [DIST_W-1:0]       dist_clamped;
    logic [A24_W-1:0]        a24;
    logic                    flush;
    logic [RANGE_W-1:0]      ln2_shifted;
    logic                    range_ge;
    logic                    range_done;
    logic [TPROD_W-1:0]      term_prod;
    logic [RECIP_W-1:0]      recip;
    logic [RSH_W-1:0]        recip_shift;
    logic [TPROD_W-1:0]      div_prod;
    logic [TPROD_W-1:0]      div_shifted;
    logic                    terms_done;
    logic signed [SUM_W-1:0] term_s;
    logic [SUM_W-1:0]        sum_pos;
    logic [SUM_W:0]          rounded;
    logic [SUM_W:0]          shifted;

    function automatic logic [RECIP_W-1:0] recip_of(input logic [K_W-1:0] k);
        case (k)
            K_W'(3), K_W'(6):  recip_of = RECIP_3;
            K_W'(5), K_W'(10): recip_of = RECIP_5;
            K_W'(7):           recip_of = RECIP_7;
            K_W'(9):           recip_of = RECIP_9;
            default:           recip_of = RECIP_POW2;
        endcase
    endfunction

    function automatic logic [RSH_W-1:0] shift_of(input logic [K_W-1:0] k);
        case (k)
            K_W'(2):                            shift_of = RSH_W'(1);
            K_W'(3), K_W'(4):                   shift_of = RSH_W'(2);
            K_W'(5), K_W'(6), K_W'(7), K_W'(8): shift_of = RSH_W'(3);
            K_W'(9), K_W'(10):                  shift_of = RSH_W'(4);
            default:                            shift_of = '0;
        endcase
    endfunction

    // datapath
    always_comb
    begin
        d_wide = DWIDE_W'($signed({1'b0, job_reg.self_dot}))
               - (DWIDE_W'($signed(job_reg.cross_dot)) <<< 1)
               + DWIDE_W'($signed({1'b0, job_reg.norm}));
        if (d_wide < 0)
            dist_clamped = '0;
        else if (d_wide > DWIDE_W'($signed({1'b0, DIST_MAX})))
            dist_clamped = DIST_MAX;
        else
            dist_clamped = d_wide[DIST_W-1:0];

        a24   = (A24_W'(prod_hi_reg) << (DIST_SPLIT - GAMMA_FRAC))
              + A24_W'(prod_lo_reg[PROD_LO_W-1:GAMMA_FRAC]);
        flush = a24 > EXP_BOUND_A24;

        ln2_shifted = RANGE_W'(LN2_Q30) << range_cnt_reg;
        range_ge    = rem_reg >= ln2_shifted;
        range_done  = (range_cnt_reg == '0);

        term_prod = TPROD_W'(term_reg) * TPROD_W'(rem_reg[Q30_W-1:0]);

        // floor(qd / k) as a multiply by a rounded-up reciprocal
        recip       = recip_of(k_reg);
        recip_shift = shift_of(k_reg);
        div_prod    = TPROD_W'(qd_reg) * TPROD_W'(recip);
        div_shifted = (div_prod >> Q30_W) >> recip_shift;
        terms_done  = (k_reg == K_W'(TAYLOR_TERMS));
        term_s      = $signed(SUM_W'(qd_reg));

        sum_pos = (sum_reg < 0) ? '0 : $unsigned(sum_reg);
        rounded = {1'b0, sum_pos} + ((SUM_W+1)'(1) << (RND_BASE + n_reg));
        shifted = rounded >> (RND_BASE + 1 + n_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (q_stat.not_empty) state_next = ST_DIST;
            ST_DIST:     state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_MUL_LO;
            ST_MUL_LO:   state_next = ST_BOUND;
            ST_BOUND:    state_next = flush ? ST_DONE : ST_RANGE;
            ST_RANGE:    if (range_done) state_next = ST_MUL_TERM;
            ST_MUL_TERM: state_next = ST_DIV;
            ST_DIV:      state_next = ST_ACCUM;
            ST_ACCUM:    state_next = terms_done ? ST_ROUND : ST_MUL_TERM;
            ST_ROUND:    state_next = ST_DONE;
            ST_DONE:     if (load_out) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: pop      = q_stat.not_empty;
            ST_DONE: load_out = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gamma_reg     <= GAMMA_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                gamma_reg <= cfg_wdata;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            kernel_out_reg <= kernel_reg;
            dist_out_reg   <= dist_reg;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                    job_reg <= pop_job;
            end
            ST_DIST:   dist_reg    <= dist_clamped;
            ST_MUL_HI: prod_hi_reg <= gamma_reg * dist_reg[DIST_W-1:DIST_SPLIT];
            ST_MUL_LO: prod_lo_reg <= gamma_reg * dist_reg[DIST_SPLIT-1:0];
            ST_BOUND:
            begin
                rem_reg       <= {a24[RANGE_W-A30_SHIFT-1:0], A30_SHIFT'(0)};
                n_reg         <= '0;
                range_cnt_reg <= RCNT_W'(N_W - 1);
                kernel_reg    <= '0;
            end
            ST_RANGE:
            begin
                if (range_ge)
                begin
                    rem_reg              <= rem_reg - ln2_shifted;
                    n_reg[range_cnt_reg] <= 1'b1;
                end
                range_cnt_reg <= range_cnt_reg - 1'b1;
                term_reg      <= ONE_Q30;
                sum_reg       <= $signed(SUM_W'(ONE_Q30));
                k_reg         <= K_W'(1);
            end
            ST_MUL_TERM: qd_reg <= term_prod[2*Q30_W-1:Q30_W];
            ST_DIV:      qd_reg <= div_shifted[Q30_W-1:0];
            ST_ACCUM:
            begin
                term_reg <= TERM_W'(qd_reg);
                sum_reg  <= k_reg[0] ? (sum_reg - term_s) : (sum_reg + term_s);
                k_reg    <= k_reg + 1'b1;
            end
            ST_ROUND:  kernel_reg <= shifted[KERNEL_W-1:0];
            default: ;
        endcase
    end

    assign out_valid        = out_valid_reg;
    assign kernel_value     = kernel_out_reg;
    assign squared_distance = dist_out_reg;

`ifndef SYNTH
    a_range_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (rem_reg < RANGE_W'(LN2_Q30)))
        else $error("exp argument not reduced below ln2");
    a_divisor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ((k_reg != '0) && (k_reg <= K_W'(TAYLOR_TERMS))))
        else $error("Taylor divisor out of range");
    a_kernel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (kernel_out_reg <= KERNEL_ONE))
        else $error("kernel value above 1.0");
`endif

endmodule

// ===== hdl/rbf_kernel_evaluator.sv =====
// ----------------------------------------------------------------------------
// rbf_kernel_evaluator
// Gaussian RBF kernel exp(-gamma*|x-y|^2) over streamed feature pairs.
//
// Input channel (in_valid/in_ready): one feature pair per transaction, with
// |y|^2 and a last flag. Pairs are taken one per cycle while the job queue
// has room; x.x and x.y are accumulated by a two-stage multiply-accumulate.
// On the last pair the vector pair enters a 4-entry job queue. The back end
// works one job at a time and evaluates exp by 10 Taylor terms, each a
// multiply, a reciprocal-multiply divide and an accumulate; it skips the
// series when exp flushes to zero. Input stalls while the queue is full or a
// pending hand-off would fill it.
// Output channel (out_valid/out_ready): kernel_value (Q1.16) and
// squared_distance (Q19.24). A stalled receiver holds the result in the
// output register while the next job computes and the front keeps accepting.
// cfg_we/cfg_wdata writes gamma (Q8.16); the user must use it only while
// idle, and the block itself does not enforce this.
// Reset: accumulators and queue empty, gamma = 1.0, no result pending.
// ----------------------------------------------------------------------------
module rbf_kernel_evaluator import rbf_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic        [GAMMA_W-1:0]      cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [FEATURE_BITS-1:0] test_feature,
    input  logic signed [FEATURE_BITS-1:0] ref_feature,
    input  logic        [NORM_W-1:0]       ref_norm_sq,
    input  logic                           last_feature,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic        [KERNEL_W-1:0]     kernel_value,
    output logic        [DIST_W-1:0]       squared_distance
);

    q_stat_t q_stat;
    logic    push;
    job_t    push_job;
    logic    pop;
    job_t    pop_job;

    rbf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .test_feature (test_feature),
        .ref_feature  (ref_feature),
        .ref_norm_sq  (ref_norm_sq),
        .last_feature (last_feature),
        .q_stat       (q_stat),
        .push         (push),
        .push_job     (push_job)
    );

    rbf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    rbf_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .q_stat           (q_stat),
        .pop_job          (pop_job),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kernel_value     (kernel_value),
        .squared_distance (squared_distance)
    );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: rbf_kernel_evaluator regression
// Streams feature pairs through the kernel evaluator with random gaps on the
// input side and random back-pressure on the result side. A behavioral
// predictor tracks x.x, x.y and gamma, forms the expected kernel value and
// squared distance for every vector pair, and the monitor checks each result
// transaction in order. Gamma is rewritten between phases once the block has
// drained, covering zero, full scale, reset value and random settings.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rbf_pkg::*;

    localparam int     CYCLE_LIMIT   = 8_000_000;
    localparam int     SETTLE_CYCLES = 400;
    localparam longint FLUSH_A30     = longint'(LN2_Q30) * 16;

    typedef struct {
        logic signed [FEATURE_BITS-1:0] x;
        logic signed [FEATURE_BITS-1:0] y;
        logic        [NORM_W-1:0]       norm;
        logic                           last;
        int                             gap;
    } feature_pair_t;

    typedef struct {
        logic [KERNEL_W-1:0] kernel;
        logic [DIST_W-1:0]   sq_dist;
    } kernel_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic        [GAMMA_W-1:0]      cfg_wdata = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic signed [FEATURE_BITS-1:0] test_feature = '0;
    logic signed [FEATURE_BITS-1:0] ref_feature = '0;
    logic        [NORM_W-1:0]       ref_norm_sq = '0;
    logic                           last_feature = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic        [KERNEL_W-1:0]     kernel_value;
    logic        [DIST_W-1:0]       squared_distance;

    feature_pair_t  feature_stream[$];
    kernel_result_t pending_kernels[$];
    feature_pair_t  cur_pair;
    feature_pair_t  staged_pair;
    bit             staged_ok = 1'b0;
    int             gap_left = 0;
    int             pairs_outstanding = 0;
    int             stall_left = 0;
    int             calm_left = 0;
    int             fail_count = 0;
    int             cycle_count = 0;

    logic [GAMMA_W-1:0] gamma_setting = GAMMA_RESET;
    longint             self_dot_sum = 0;
    longint             cross_dot_sum = 0;

    rbf_kernel_evaluator uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .test_feature     (test_feature),
        .ref_feature      (ref_feature),
        .ref_norm_sq      (ref_norm_sq),
        .last_feature     (last_feature),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kernel_value     (kernel_value),
        .squared_distance (squared_distance)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // exp(-a) with a in Q.24, result Q1.16
    function automatic logic [KERNEL_W-1:0] decay_q16(input longint a24);
        longint ln2, a30, n, r30, sum, term;
        ln2 = longint'(LN2_Q30);
        if (a24 > (FLUSH_A30 >>> A30_SHIFT))
            return '0;
        a30 = a24 <<< A30_SHIFT;
        if (a30 > FLUSH_A30)
            return '0;
        n = a30 / ln2;
        r30 = a30 - n * ln2;
        sum = longint'(ONE_Q30);
        term = sum;
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            term = ((term * r30) >>> Q30_W) / k;
            if (k % 2 == 1)
                sum -= term;
            else
                sum += term;
        end
        if (sum < 0)
            sum = 0;
        return KERNEL_W'((sum + (longint'(1) << (RND_BASE + n))) >>> (RND_BASE + 1 + n));
    endfunction

    function automatic longint saturate_acc(input longint v);
        longint hi;
        hi = longint'(ACC_MAX);
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic bit absorb_feature_pair(input feature_pair_t p,
                                               output kernel_result_t r);
        longint sq_dist, g, a24;
        self_dot_sum  = saturate_acc(self_dot_sum + longint'(p.x) * longint'(p.x));
        cross_dot_sum = saturate_acc(cross_dot_sum + longint'(p.x) * longint'(p.y));
        if (!p.last)
            return 1'b0;
        sq_dist = self_dot_sum - 2 * cross_dot_sum + longint'(p.norm);
        if (sq_dist < 0)
            sq_dist = 0;
        if (sq_dist > longint'(DIST_MAX))
            sq_dist = longint'(DIST_MAX);
        g = longint'(gamma_setting);
        a24 = ((g * (sq_dist >>> DIST_SPLIT)) << (DIST_SPLIT - GAMMA_FRAC))
            + ((g * (sq_dist & ((longint'(1) << DIST_SPLIT) - 1))) >>> GAMMA_FRAC);
        r.kernel = decay_q16(a24);
        r.sq_dist = sq_dist[DIST_W-1:0];
        self_dot_sum = 0;
        cross_dot_sum = 0;
        return 1'b1;
    endfunction

    function automatic logic signed [FEATURE_BITS-1:0] clip_feature(input int v);
        int hi;
        hi = (1 << (FEATURE_BITS - 1)) - 1;
        if (v > hi)
            return FEATURE_BITS'(hi);
        if (v < -hi - 1)
            return FEATURE_BITS'(-hi - 1);
        return FEATURE_BITS'(v);
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 60);
    endfunction

    function automatic int stall_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 4);
        if (r < 95)
            return $urandom_range(5, 60);
        return $urandom_range(200, 600);
    endfunction

    task automatic queue_pair(input int x,
                              input int y,
                              input longint norm,
                              input bit last,
                              input int gap);
        feature_pair_t p;
        p.x = FEATURE_BITS'(x);
        p.y = FEATURE_BITS'(y);
        p.norm = NORM_W'(norm);
        p.last = last;
        p.gap = gap;
        feature_stream.push_back(p);
        pairs_outstanding++;
    endtask

    task automatic queue_directed();
        longint ones;
        ones = (longint'(1) << NORM_W) - 1;
        queue_pair(0, 0, 0, 1'b1, 0);
        queue_pair(0, 0, longint'(LN2_Q30) >>> A30_SHIFT, 1'b1, 0);
        queue_pair(0, 0, (longint'(LN2_Q30) >>> A30_SHIFT) + 1, 1'b1, 0);
        queue_pair(0, 0, longint'(1) << 24, 1'b1, 1);
        queue_pair(0, 0, FLUSH_A30 >>> A30_SHIFT, 1'b1, 0);
        queue_pair(0, 0, (FLUSH_A30 >>> A30_SHIFT) + 1, 1'b1, 2);
        // x.y equals x.x with zero norm: distance clamps to zero
        queue_pair(16384, 16384, 0, 1'b1, 0);
        queue_pair(-32768, -32768, longint'({$urandom, $urandom}), 1'b0, 0);
        queue_pair(32767, -32768, longint'({$urandom, $urandom}), 1'b0, 3);
        queue_pair(32767, 32767, longint'({$urandom, $urandom}), 1'b0, 0);
        queue_pair(-1, 1, ones, 1'b1, 0);
        queue_pair(-32768, 32767, ones, 1'b1, 0);
        queue_pair(21845, -21846, 64'h0AA_AAAA_AAAA, 1'b0, 0);
        queue_pair(-21846, 21845, 64'h155_5555_5555, 1'b1, 0);
        queue_pair(1, -1, 0, 1'b1, 0);
        queue_pair(4096, 0, longint'(1) << 24, 1'b1, 0);
    endtask

    task automatic queue_random_vectors(input int budget);
        int r, len, kind, amp, shift, noise;
        bit calm, last;
        longint norm_sum;
        logic signed [FEATURE_BITS-1:0] x, y;
        logic [NORM_W-1:0] norm;
        while (budget > 0)
        begin
            r = $urandom_range(0, 99);
            len = (r < 60) ? $urandom_range(1, 8)
                : (r < 90) ? $urandom_range(9, 32) : $urandom_range(33, 200);
            kind = $urandom_range(0, 99);
            amp = 1 << $urandom_range(0, 15);
            shift = $urandom_range(0, 10);
            calm = ($urandom_range(0, 3) == 0);
            norm_sum = 0;
            for (int i = 0; i < len; i++)
            begin
                if (kind < 55)
                begin
                    y = FEATURE_BITS'($urandom);
                    y = y >>> shift;
                    noise = int'($urandom_range(0, 2 * amp)) - amp;
                    x = clip_feature(int'(y) + noise);
                end
                else
                begin
                    x = FEATURE_BITS'($urandom);
                    y = FEATURE_BITS'($urandom);
                end
                norm_sum += longint'(y) * longint'(y);
                last = (i == len - 1) && (kind < 96);
                if (last && kind < 85)
                    norm = norm_sum[NORM_W-1:0];
                else
                    norm = NORM_W'({$urandom, $urandom});
                queue_pair(int'(x), int'(y), longint'(norm), last,
                           calm ? 0 : idle_length());
            end
            budget -= len;
        end
    endtask

    task automatic settle();
        while (pairs_outstanding != 0 || pending_kernels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_gamma(input logic [GAMMA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        gamma_setting = value;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_directed();
        settle();

        write_gamma('0);
        queue_random_vectors(140);
        settle();

        write_gamma('1);
        queue_random_vectors(240);
        settle();

        write_gamma(GAMMA_W'($urandom_range(1, 255)));
        queue_random_vectors(200);
        settle();

        write_gamma(GAMMA_W'($urandom_range(0, (1 << GAMMA_W) - 1)));
        queue_random_vectors(200);
        settle();

        write_gamma(GAMMA_W'($urandom_range(16'h4000, 24'h04_0000)));
        queue_random_vectors(240);
        settle();

        // back at 1.0
        write_gamma(GAMMA_RESET);
        queue_random_vectors(260);
        settle();

        if (fail_count == 0)
            $display("rbf_kernel_evaluator regression: pass");
        else
            $display("rbf_kernel_evaluator regression: fail");
        $finish;
    end

    always @(posedge clk)
    begin : feed_driver
        kernel_result_t outcome;
        logic           launch;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (absorb_feature_pair(cur_pair, outcome))
                    pending_kernels.push_back(outcome);
                pairs_outstanding--;
            end
            if (!in_valid || in_ready)
            begin
                launch = 1'b0;
                if (!staged_ok && feature_stream.size() != 0)
                begin
                    staged_pair = feature_stream.pop_front();
                    staged_ok = 1'b1;
                    gap_left = staged_pair.gap;
                end
                if (staged_ok)
                begin
                    if (gap_left != 0)
                    begin
                        gap_left--;
                    end
                    else
                    begin
                        launch = 1'b1;
                        staged_ok = 1'b0;
                        cur_pair <= staged_pair;
                        test_feature <= staged_pair.x;
                        ref_feature <= staged_pair.y;
                        ref_norm_sq <= staged_pair.norm;
                        last_feature <= staged_pair.last;
                    end
                end
                in_valid <= launch;
            end
        end
    end

    always @(posedge clk)
    begin : sink_pacing
        int r;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (calm_left != 0)
        begin
            calm_left--;
            out_ready <= 1'b1;
        end
        else
        begin
            r = $urandom_range(0, 999);
            if (r < 3)
            begin
                calm_left = $urandom_range(200, 1500);
                out_ready <= 1'b1;
            end
            else if (r < 25)
            begin
                stall_left = stall_length();
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        kernel_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_kernels.size() == 0)
            begin
                $error("unexpected transaction: kernel_value %0d squared_distance %0d",
                       kernel_value, squared_distance);
                fail_count++;
            end
            else
            begin
                want = pending_kernels.pop_front();
                if (kernel_value !== want.kernel)
                begin
                    $error("kernel_value mismatch: expected %0d, actual %0d",
                           want.kernel, kernel_value);
                    fail_count++;
                end
                if (squared_distance !== want.sq_dist)
                begin
                    $error("squared_distance mismatch: expected %0d, actual %0d",
                           want.sq_dist, squared_distance);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rbf_kernel_evaluator regression: fail");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
hdl/rbf_pkg.sv
hdl/rbf_front.sv
hdl/rbf_queue.sv
hdl/rbf_back.sv
hdl/rbf_kernel_evaluator.sv
tb/tb_top.sv
